/* rtl/prpull_pkg.sv */
package prpull_pkg;

   localparam int RANK_BITS          = 32;
   localparam int DEGREE_FIELD_BITS  = 16;
   localparam int DEGREE_BITS        = 16;
   localparam int DEG_USED_BITS      = (DEGREE_BITS < DEGREE_FIELD_BITS) ?
                                       DEGREE_BITS : DEGREE_FIELD_BITS;
   localparam int ALPHA_BITS         = 16;
   localparam int WEIGHT_BITS        = ALPHA_BITS + 1;
   localparam int SUM_BITS           = 48;
   localparam int FRAC_BITS          = 16;
   localparam logic [ALPHA_BITS-1:0] ALPHA_RESET = 16'd9830;

endpackage

/* rtl/prpull_req_if.sv */
interface prpull_req_if;
   import prpull_pkg::*;

   logic                         valid;
   logic                         ready;
   logic [RANK_BITS-1:0]         neighbor_rank;
   logic [DEGREE_FIELD_BITS-1:0] neighbor_out_degree;
   logic                         no_edge;
   logic                         last_edge;

   modport source (output valid, output neighbor_rank, output neighbor_out_degree,
                   output no_edge, output last_edge, input ready);
   modport sink   (input valid, input neighbor_rank, input neighbor_out_degree,
                   input no_edge, input last_edge, output ready);
endinterface

/* rtl/prpull_rsp_if.sv */
interface prpull_rsp_if;
   import prpull_pkg::*;

   logic                 valid;
   logic                 ready;
   logic [RANK_BITS-1:0] new_rank;
   logic                 saturated;
   logic                 zero_degree_seen;

   modport source (output valid, output new_rank, output saturated,
                   output zero_degree_seen, input ready);
   modport sink   (input valid, input new_rank, input saturated,
                   input zero_degree_seen, output ready);
endinterface

/* rtl/pagerank_pull_node_update.sv */
// An edge request is loaded on acceptance, run through the radix-2 restoring divider,
// then accumulated into the sum; the next request is taken only after that.
// A last-edge request then passes through two halves of the shared 24x17 multiplier
// and the saturation state, which holds until the full output register is taken.
// A request without a division keeps the block idle, unless it closes the node.
// Synchronous active-high reset clears the sum, the flag, and sets alpha to 9830.
module pagerank_pull_node_update (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_write_enable,
   input  logic [prpull_pkg::ALPHA_BITS-1:0] csr_write_data,
   prpull_req_if.sink                        req_chan,
   prpull_rsp_if.source                      rsp_chan
);
   import prpull_pkg::*;

   localparam int HALF_BITS  = SUM_BITS / 2;
   localparam int MUL_BITS   = HALF_BITS + WEIGHT_BITS;
   localparam int PROD_BITS  = SUM_BITS + WEIGHT_BITS;
   localparam int SHIFT_BITS = PROD_BITS - FRAC_BITS;
   localparam int RES_BITS   = SHIFT_BITS + 1;
   localparam int CNT_BITS   = $clog2(RANK_BITS);
   localparam logic [CNT_BITS-1:0] CNT_LAST = CNT_BITS'(RANK_BITS - 1);
   localparam logic [SUM_BITS-1:0] SUM_MAX  = {SUM_BITS{1'b1}};
   localparam logic [RANK_BITS-1:0] RANK_MAX = {RANK_BITS{1'b1}};

   typedef enum logic [5:0] {
      ST_IDLE   = 6'b000001,
      ST_DIVIDE = 6'b000010,
      ST_ACCUM  = 6'b000100,
      ST_MUL_LO = 6'b001000,
      ST_MUL_HI = 6'b010000,
      ST_FINISH = 6'b100000
   } state_type;

   state_type                state_ff, state_in;
   logic [ALPHA_BITS-1:0]    alpha_ff, alpha_in;
   logic [SUM_BITS-1:0]      sum_ff, sum_in;
   logic                     flag_ff, flag_in;
   logic                     last_ff, last_in;
   logic [DEG_USED_BITS-1:0] div_ff, div_in;
   logic [DEG_USED_BITS-1:0] rem_ff, rem_in;
   logic [RANK_BITS-1:0]     quo_ff, quo_in;
   logic [CNT_BITS-1:0]      cnt_ff, cnt_in;
   logic [PROD_BITS-1:0]     prod_ff, prod_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic [RANK_BITS-1:0]     rsp_rank_ff, rsp_rank_in;
   logic                     rsp_sat_ff, rsp_sat_in;
   logic                     rsp_zero_ff, rsp_zero_in;

   logic [DEG_USED_BITS-1:0] req_degree;
   logic [DEG_USED_BITS:0]   trial;
   logic [DEG_USED_BITS:0]   diff;
   logic                     trial_ge;
   logic [SUM_BITS:0]        sum_ext;
   logic [WEIGHT_BITS-1:0]   weight;
   logic [HALF_BITS-1:0]     mul_a;
   logic [MUL_BITS-1:0]      mul_p;
   logic [RES_BITS-1:0]      result;
   logic                     out_free;
   logic                     req_accept;

   assign req_chan.ready = (state_ff == ST_IDLE);
   assign req_accept     = req_chan.valid && req_chan.ready;
   assign req_degree     = req_chan.neighbor_out_degree[DEG_USED_BITS-1:0];

   assign trial    = {rem_ff, quo_ff[RANK_BITS-1]};
   assign diff     = trial - {1'b0, div_ff};
   assign trial_ge = (trial >= {1'b0, div_ff});

   assign sum_ext = {1'b0, sum_ff} + (SUM_BITS + 1)'(quo_ff);

   assign weight = (WEIGHT_BITS'(1) << ALPHA_BITS) - WEIGHT_BITS'(alpha_ff);
   assign mul_a  = (state_ff == ST_MUL_LO) ? sum_ff[HALF_BITS-1:0]
                                           : sum_ff[SUM_BITS-1:HALF_BITS];
   assign mul_p  = MUL_BITS'(mul_a) * MUL_BITS'(weight);

   assign result   = {1'b0, prod_ff[PROD_BITS-1:FRAC_BITS]} + RES_BITS'(alpha_ff);
   assign out_free = !rsp_valid_ff || rsp_chan.ready;

   always_comb begin
      state_in     = state_ff;
      alpha_in     = alpha_ff;
      sum_in       = sum_ff;
      flag_in      = flag_ff;
      last_in      = last_ff;
      div_in       = div_ff;
      rem_in       = rem_ff;
      quo_in       = quo_ff;
      cnt_in       = cnt_ff;
      prod_in      = prod_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      rsp_rank_in  = rsp_rank_ff;
      rsp_sat_in   = rsp_sat_ff;
      rsp_zero_in  = rsp_zero_ff;

      if (csr_write_enable) begin
         alpha_in = csr_write_data;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               last_in = req_chan.last_edge;
               div_in  = req_degree;
               rem_in  = '0;
               quo_in  = req_chan.neighbor_rank;
               cnt_in  = '0;
               if (!req_chan.no_edge && (req_degree != '0)) begin
                  state_in = ST_DIVIDE;
               end else begin
                  if (!req_chan.no_edge) begin
                     flag_in = 1'b1;
                  end
                  if (req_chan.last_edge) begin
                     state_in = ST_MUL_LO;
                  end
               end
            end
         end
         ST_DIVIDE: begin
            rem_in = trial_ge ? diff[DEG_USED_BITS-1:0] : trial[DEG_USED_BITS-1:0];
            quo_in = {quo_ff[RANK_BITS-2:0], trial_ge};
            cnt_in = cnt_ff + CNT_BITS'(1);
            if (cnt_ff == CNT_LAST) begin
               state_in = ST_ACCUM;
            end
         end
         ST_ACCUM: begin
            sum_in   = sum_ext[SUM_BITS] ? SUM_MAX : sum_ext[SUM_BITS-1:0];
            state_in = last_ff ? ST_MUL_LO : ST_IDLE;
         end
         ST_MUL_LO: begin
            prod_in  = PROD_BITS'(mul_p);
            state_in = ST_MUL_HI;
         end
         ST_MUL_HI: begin
            prod_in  = prod_ff + {mul_p, {HALF_BITS{1'b0}}};
            state_in = ST_FINISH;
         end
         ST_FINISH: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_sat_in   = |result[RES_BITS-1:RANK_BITS];
               rsp_rank_in  = rsp_sat_in ? RANK_MAX : result[RANK_BITS-1:0];
               rsp_zero_in  = flag_ff;
               sum_in       = '0;
               flag_in      = 1'b0;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         alpha_ff     <= ALPHA_RESET;
         sum_ff       <= '0;
         flag_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         alpha_ff     <= alpha_in;
         sum_ff       <= sum_in;
         flag_ff      <= flag_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      last_ff     <= last_in;
      div_ff      <= div_in;
      rem_ff      <= rem_in;
      quo_ff      <= quo_in;
      cnt_ff      <= cnt_in;
      prod_ff     <= prod_in;
      rsp_rank_ff <= rsp_rank_in;
      rsp_sat_ff  <= rsp_sat_in;
      rsp_zero_ff <= rsp_zero_in;
   end

   assign rsp_chan.valid            = rsp_valid_ff;
   assign rsp_chan.new_rank         = rsp_rank_ff;
   assign rsp_chan.saturated        = rsp_sat_ff;
   assign rsp_chan.zero_degree_seen = rsp_zero_ff;

endmodule
